>>> rtl/untp_pkg.sv
// Package for the unsigned number text parser.
// Holds the character codes, limits and character class helpers.
// No dependencies.
package untp_pkg;

    // Byte codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_ONE   = 8'h31;
    localparam logic [7:0] CHAR_SEVEN = 8'h37;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LO_A  = 8'h61;
    localparam logic [7:0] CHAR_LO_F  = 8'h66;
    localparam logic [7:0] CHAR_UP_A  = 8'h41;
    localparam logic [7:0] CHAR_UP_F  = 8'h46;
    localparam logic [7:0] CHAR_LO_X  = 8'h78;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;

    // Result limits
    localparam logic [31:0] FAIL_VALUE = 32'hFFFF_FFFF;

    // Digit value for "not a hex digit"
    localparam logic [4:0] NO_DIGIT = 5'd16;

    // Space and the control bytes tab through carriage return
    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // Hex digit value, or NO_DIGIT
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            v = c - CHAR_ZERO;
            return v[4:0];
        end
        if (c >= CHAR_LO_A && c <= CHAR_LO_F)
        begin
            v = c - CHAR_LO_A + 8'd10;
            return v[4:0];
        end
        if (c >= CHAR_UP_A && c <= CHAR_UP_F)
        begin
            v = c - CHAR_UP_A + 8'd10;
            return v[4:0];
        end
        return NO_DIGIT;
    endfunction

endpackage

>>> rtl/unsigned_number_text_parser.sv
// Unsigned number text parser: a base-0 style text to 32-bit integer converter.
// Depends on untp_pkg.
//
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata/s_tlast) carries one text byte
//   per transfer; s_tlast marks the last byte of the text. A NUL byte ends the
//   text early and the bytes after it, up to s_tlast, are ignored.
//   Master stream (m_tvalid/m_tready/m_tdata/m_tuser) carries one result per
//   text: the value in m_tdata, or all ones with m_tuser = 1 on a parse error.
//   Bytes without s_tlast produce no transfer on the master side.
// Timing:
//   One byte per cycle sustained while no last byte waits for a stalled result.
//   A byte is held in an input register, then the parse state and, on the last
//   byte, the result register, which drives m_tvalid, are updated from it.
//   The per-byte update is a constant radix multiply-add (shifts and adds)
//   plus the phase logic.
// Reset and stall:
//   rst_n clears the parse state to the start of a new text and empties both
//   registers. When m_tready is low with a result waiting, non-last bytes are
//   still taken; a last byte waits in the input register and s_tready drops
//   until the result has been transferred.
module unsigned_number_text_parser
    import untp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // is_last
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] parsed_value
    output logic        m_tuser    // [0] parse_error
);

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_ZERO,
        PH_HEXPFX,
        PH_DIGITS
    } phase_t;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } base_t;

    // Input register
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Parse state
    phase_t      phase_reg, phase_next;
    base_t       base_reg, base_next;
    logic [31:0] mag_reg, mag_next;
    logic        ovf_reg, ovf_next;
    logic        minus_reg, minus_next;
    logic        err_reg, err_next;
    logic        ended_reg, ended_next;

    // Result register
    logic        out_valid_reg;
    logic [31:0] out_value_reg;
    logic        out_error_reg;

    logic        out_free;
    logic        advance;
    logic [4:0]  digit;
    logic [4:0]  radix;
    logic [35:0] scaled;
    logic [35:0] acc_sum;
    logic        fail;

    // Handshake: a last byte needs a free result register
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_error_reg;

    // Digit value and radix multiply-add
    assign digit = hex_value(in_byte_reg);

    always_comb
    begin
        unique case (base_reg)
            BASE_OCT:
            begin
                radix  = 5'd8;
                scaled = {1'b0, mag_reg, 3'b000};
            end
            BASE_HEX:
            begin
                radix  = 5'd16;
                scaled = {mag_reg, 4'b0000};
            end
            default:
            begin
                radix  = 5'd10;
                scaled = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0};
            end
        endcase
    end

    assign acc_sum = scaled + {31'd0, digit};

    // Per-byte parse step
    always_comb
    begin
        phase_next = phase_reg;
        base_next  = base_reg;
        mag_next   = mag_reg;
        ovf_next   = ovf_reg;
        minus_next = minus_reg;
        err_next   = err_reg;
        ended_next = ended_reg;

        if (!err_reg && !ended_reg)
        begin
            unique case (phase_reg)
                PH_START, PH_SIGN:
                begin
                    if (in_byte_reg == CHAR_NUL)
                    begin
                        err_next   = 1'b1;
                        ended_next = 1'b1;
                    end
                    else if (phase_reg == PH_START && is_blank(in_byte_reg))
                    begin
                        phase_next = PH_START;
                    end
                    else if (phase_reg == PH_START && in_byte_reg == CHAR_PLUS)
                    begin
                        phase_next = PH_SIGN;
                    end
                    else if (phase_reg == PH_START && in_byte_reg == CHAR_MINUS)
                    begin
                        minus_next = 1'b1;
                        phase_next = PH_SIGN;
                    end
                    else if (in_byte_reg == CHAR_ZERO)
                    begin
                        phase_next = PH_ZERO;
                    end
                    else if (in_byte_reg >= CHAR_ONE && in_byte_reg <= CHAR_NINE)
                    begin
                        base_next  = BASE_DEC;
                        mag_next   = {27'd0, digit};
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_ZERO:
                begin
                    if (in_byte_reg == CHAR_NUL)
                    begin
                        ended_next = 1'b1;
                    end
                    else if (in_byte_reg == CHAR_LO_X || in_byte_reg == CHAR_UP_X)
                    begin
                        phase_next = PH_HEXPFX;
                    end
                    else if (in_byte_reg >= CHAR_ZERO && in_byte_reg <= CHAR_SEVEN)
                    begin
                        base_next  = BASE_OCT;
                        mag_next   = {27'd0, digit};
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                PH_HEXPFX:
                begin
                    if (digit != NO_DIGIT)
                    begin
                        base_next  = BASE_HEX;
                        mag_next   = {27'd0, digit};
                        phase_next = PH_DIGITS;
                    end
                    else
                    begin
                        err_next = 1'b1;
                        if (in_byte_reg == CHAR_NUL)
                            ended_next = 1'b1;
                    end
                end
                PH_DIGITS:
                begin
                    if (in_byte_reg == CHAR_NUL)
                    begin
                        ended_next = 1'b1;
                    end
                    else if (digit < radix)
                    begin
                        mag_next = acc_sum[31:0];
                        if (acc_sum[35:32] != 4'd0)
                            ovf_next = 1'b1;
                    end
                    else
                    begin
                        err_next = 1'b1;
                    end
                end
                default:
                begin
                    err_next = 1'b1;
                end
            endcase
        end
    end

    // End of text: an implicit NUL fails in the start, sign and prefix phases
    assign fail = err_next || ovf_next || (mag_next == FAIL_VALUE)
                || (minus_next && mag_next != 32'd0)
                || (!ended_next && (phase_next == PH_START || phase_next == PH_SIGN
                                    || phase_next == PH_HEXPFX));

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Parse state; back to start after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            base_reg  <= BASE_DEC;
            mag_reg   <= 32'd0;
            ovf_reg   <= 1'b0;
            minus_reg <= 1'b0;
            err_reg   <= 1'b0;
            ended_reg <= 1'b0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                phase_reg <= PH_START;
                base_reg  <= BASE_DEC;
                mag_reg   <= 32'd0;
                ovf_reg   <= 1'b0;
                minus_reg <= 1'b0;
                err_reg   <= 1'b0;
                ended_reg <= 1'b0;
            end
            else
            begin
                phase_reg <= phase_next;
                base_reg  <= base_next;
                mag_reg   <= mag_next;
                ovf_reg   <= ovf_next;
                minus_reg <= minus_next;
                err_reg   <= err_next;
                ended_reg <= ended_next;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && in_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_value_reg <= fail ? FAIL_VALUE : mag_next;
            out_error_reg <= fail;
        end
    end

endmodule

>>> rtl/untp_checker.sv
// Port-level checker for unsigned_number_text_parser, with its bind.
// Depends on untp_pkg.
module untp_checker
    import untp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,   // [7:0] text_byte
    input logic        s_tlast,   // is_last
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,   // [31:0] parsed_value
    input logic        m_tuser    // [0] parse_error
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A stalled input byte holds
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tlast))
        else $error("input byte changed while stalled");

    // An error always carries the failure value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == FAIL_VALUE)
        else $error("error without failure value");

    // A good result never equals the failure value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata != FAIL_VALUE)
        else $error("failure value without error flag");

    // Input stalls only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled with result side free");

endmodule

bind unsigned_number_text_parser untp_checker u_untp_checker (.*);

>>> bench/testbench.sv
// Stream testbench for unsigned_number_text_parser: random and directed texts go in
// byte by byte, each result is checked against an in-bench parser model.
// Depends on untp_pkg and the parser RTL.
`timescale 1ns / 100ps

module testbench;
    import untp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int TARGET_BYTES = 520;
    localparam int SETTLE_WAIT  = 12;
    localparam int MAX_REPORTS  = 10;

    // Parser model phases and bases
    typedef enum logic [2:0] {
        PHASE_START,
        PHASE_SIGN,
        PHASE_ZERO,
        PHASE_HEX_PREFIX,
        PHASE_DIGITS
    } model_phase_t;

    typedef enum logic [1:0] {
        RADIX_DEC,
        RADIX_OCT,
        RADIX_HEX
    } model_radix_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
        logic       hold_for_drain;
    } text_byte_t;

    typedef struct packed {
        logic [31:0] value;
        logic        bad;
    } parse_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] text_byte
    logic        s_tlast = 1'b0;    // is_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [31:0] parsed_value
    logic        m_tuser;           // [0] parse_error

    text_byte_t    text_bytes[$];
    parse_result_t expected_results[$];
    logic [7:0]    text_buf[$];

    int byte_total = 0;
    int text_total = 0;
    int fail_count = 0;
    int cycle_count = 0;

    // Model state
    model_phase_t pr_phase;
    model_radix_t pr_radix;
    logic [31:0]  pr_magnitude;
    logic         pr_overflow;
    logic         pr_minus;
    logic         pr_error;
    logic         pr_ended;

    unsigned_number_text_parser uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Parser model
    // ---------------------------------------------------------------

    function automatic bit blank_char(input logic [7:0] c);
        return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    // Value of a hex digit, NO_DIGIT for anything else
    function automatic logic [4:0] digit_weight(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
            return 5'(c - CHAR_ZERO);
        else if (c[6] && folded >= CHAR_LO_A && folded <= CHAR_LO_F)
            return 5'(folded - CHAR_LO_A + 8'd10);
        else
            return NO_DIGIT;
    endfunction

    function automatic int radix_of(input model_radix_t r);
        case (r)
            RADIX_OCT: return 8;
            RADIX_HEX: return 16;
            default:   return 10;
        endcase
    endfunction

    task automatic reset_parser();
        pr_phase     = PHASE_START;
        pr_radix     = RADIX_DEC;
        pr_magnitude = '0;
        pr_overflow  = 1'b0;
        pr_minus     = 1'b0;
        pr_error     = 1'b0;
        pr_ended     = 1'b0;
    endtask

    // First byte of the digits, after blanks or a sign
    task automatic begin_digits(input logic [7:0] c);
        if (c == CHAR_ZERO)
            pr_phase = PHASE_ZERO;
        else if (c >= CHAR_ONE && c <= CHAR_NINE)
        begin
            pr_radix     = RADIX_DEC;
            pr_magnitude = 32'(c - CHAR_ZERO);
            pr_phase     = PHASE_DIGITS;
        end
        else
            pr_error = 1'b1;
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic [4:0]  d;
        logic [63:0] wide;
        d = digit_weight(c);
        if (!pr_error && !pr_ended)
        begin
            case (pr_phase)
                PHASE_START:
                begin
                    if (c == CHAR_NUL)
                    begin
                        pr_error = 1'b1;
                        pr_ended = 1'b1;
                    end
                    else if (blank_char(c))
                    begin
                    end
                    else if (c == CHAR_PLUS)
                        pr_phase = PHASE_SIGN;
                    else if (c == CHAR_MINUS)
                    begin
                        pr_minus = 1'b1;
                        pr_phase = PHASE_SIGN;
                    end
                    else
                        begin_digits(c);
                end
                PHASE_SIGN:
                begin
                    if (c == CHAR_NUL)
                    begin
                        pr_error = 1'b1;
                        pr_ended = 1'b1;
                    end
                    else
                        begin_digits(c);
                end
                PHASE_ZERO:
                begin
                    if (c == CHAR_NUL)
                        pr_ended = 1'b1;
                    else if (c == CHAR_LO_X || c == CHAR_UP_X)
                        pr_phase = PHASE_HEX_PREFIX;
                    else if (c >= CHAR_ZERO && c <= CHAR_SEVEN)
                    begin
                        pr_radix     = RADIX_OCT;
                        pr_magnitude = 32'(d);
                        pr_phase     = PHASE_DIGITS;
                    end
                    else
                        pr_error = 1'b1;
                end
                PHASE_HEX_PREFIX:
                begin
                    if (d != NO_DIGIT)
                    begin
                        pr_radix     = RADIX_HEX;
                        pr_magnitude = 32'(d);
                        pr_phase     = PHASE_DIGITS;
                    end
                    else
                    begin
                        pr_error = 1'b1;
                        if (c == CHAR_NUL)
                            pr_ended = 1'b1;
                    end
                end
                PHASE_DIGITS:
                begin
                    if (c == CHAR_NUL)
                        pr_ended = 1'b1;
                    else if (int'(d) < radix_of(pr_radix))
                    begin
                        wide = {32'd0, pr_magnitude} * 64'(radix_of(pr_radix)) + 64'(d);
                        if (wide[63:32] != 32'd0)
                            pr_overflow = 1'b1;
                        pr_magnitude = wide[31:0];
                    end
                    else
                        pr_error = 1'b1;
                end
                default:
                    pr_error = 1'b1;
            endcase
        end
    endtask

    // One accepted byte; the last byte of a text yields a result
    task automatic predict_byte(input logic [7:0] c, input logic last);
        parse_result_t r;
        bit            bad;
        parse_char(c);
        if (last)
        begin
            parse_char(CHAR_NUL);
            bad = pr_error || pr_overflow || (pr_magnitude == FAIL_VALUE) ||
                  (pr_minus && pr_magnitude != 32'd0);
            r.value = bad ? FAIL_VALUE : pr_magnitude;
            r.bad   = bad;
            expected_results.push_back(r);
            reset_parser();
        end
    endtask

    // ---------------------------------------------------------------
    // Text generation
    // ---------------------------------------------------------------

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    // Queue the built text as transfers; tlast on its final byte
    task automatic emit_text(input bit drain_first);
        text_byte_t b;
        for (int i = 0; i < text_buf.size(); i++)
        begin
            b.code           = text_buf[i];
            b.last           = (i == text_buf.size() - 1);
            b.hold_for_drain = drain_first && (i == 0);
            text_bytes.push_back(b);
        end
        byte_total += text_buf.size();
        text_total++;
        text_buf.delete();
    endtask

    // Mostly characters that matter to the parser, some of any value
    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 7))
            0: return CHAR_SPACE;
            1: return 8'($urandom_range(CHAR_TAB, CHAR_CR));
            2: return ($urandom_range(0, 1) != 0) ? CHAR_PLUS : CHAR_MINUS;
            3: return 8'($urandom_range(CHAR_ZERO, CHAR_NINE));
            4: return ($urandom_range(0, 1) != 0) ? CHAR_LO_X : CHAR_UP_X;
            5: return 8'($urandom_range(CHAR_UP_A, CHAR_UP_F) | ($urandom_range(0, 1) << 5));
            6: return CHAR_NUL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_digits(input logic [63:0] v, input int radix, input bit upper);
        logic [7:0] rev[$];
        int         d;
        while (v != 64'd0)
        begin
            d = int'(v % 64'(radix));
            if (d < 10)
                rev.push_front(8'(CHAR_ZERO + d));
            else
                rev.push_front(8'((upper ? CHAR_UP_A : CHAR_LO_A) + d - 10));
            v = v / 64'(radix);
        end
        if (rev.size() == 0)
            rev.push_back(CHAR_ZERO);
        foreach (rev[i])
            text_buf.push_back(rev[i]);
    endtask

    // Number text: blanks, sign, prefix, digits and a tail
    task automatic build_number();
        logic [63:0] v;
        int          n;
        int          radix_pick;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        for (int i = 0; i < n; i++)
            text_buf.push_back(($urandom_range(0, 1) != 0) ? CHAR_SPACE :
                               8'($urandom_range(CHAR_TAB, CHAR_CR)));
        case ($urandom_range(0, 5))
            0: text_buf.push_back(CHAR_PLUS);
            1: text_buf.push_back(CHAR_MINUS);
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: v = 64'($urandom);
            3, 4:    v = 64'($urandom_range(0, 999));
            5:       v = 64'd0;
            6:       v = 64'hFFFF_FFFE;
            7:       v = 64'hFFFF_FFFF;
            8:       v = 64'h1_0000_0000;
            default: v = {24'd0, 8'($urandom_range(1, 255)), 32'($urandom)};
        endcase
        radix_pick = $urandom_range(0, 2);
        if (radix_pick == 0)
            push_digits(v, 10, 1'b0);
        else if (radix_pick == 1)
        begin
            text_buf.push_back(CHAR_ZERO);
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
                text_buf.push_back(CHAR_ZERO);
            if (v != 64'd0 || $urandom_range(0, 1) != 0)
                push_digits(v, 8, 1'b0);
        end
        else
        begin
            text_buf.push_back(CHAR_ZERO);
            text_buf.push_back(($urandom_range(0, 1) != 0) ? CHAR_LO_X : CHAR_UP_X);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
            for (int i = 0; i < n; i++)
                text_buf.push_back(CHAR_ZERO);
            push_digits(v, 16, $urandom_range(0, 1) != 0);
        end
        // tail: early end with ignored bytes, junk, or nothing
        case ($urandom_range(0, 9))
            0:
            begin
                text_buf.push_back(CHAR_NUL);
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                    text_buf.push_back(pick_char());
            end
            1: text_buf.push_back(pick_char());
            2: text_buf.push_back(CHAR_SPACE);
            default: ;
        endcase
        // occasional damage anywhere in the text
        if ($urandom_range(0, 7) == 0)
            text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
    endtask

    task automatic build_noise();
        int n;
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++)
            text_buf.push_back(pick_char());
    endtask

    // ---------------------------------------------------------------
    // Mismatch bookkeeping
    // ---------------------------------------------------------------

    task automatic report_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("[%0d] %s mismatch: expected %h, got %h", cycle_count, field, want, got);
    endtask

    // ---------------------------------------------------------------
    // Driver: one text byte per transfer, random gaps between bytes
    // ---------------------------------------------------------------

    int send_gap = 0;
    int send_quiet = 0;
    bit send_valid;
    text_byte_t send_item;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid   <= 1'b0;
            s_tdata    <= 8'h00;
            s_tlast    <= 1'b0;
            send_gap   <= 0;
            send_quiet <= 0;
        end
        else
        begin
            send_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                predict_byte(s_tdata, s_tlast);
                send_valid = 1'b0;
            end
            if (!send_valid)
            begin
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
                else if (text_bytes.size() != 0 &&
                         !(text_bytes[0].hold_for_drain && expected_results.size() != 0))
                begin
                    send_item = text_bytes.pop_front();
                    s_tdata   <= send_item.code;
                    s_tlast   <= send_item.last;
                    send_valid = 1'b1;
                    // quiet stretches send back to back
                    if (send_quiet > 0)
                    begin
                        send_quiet <= send_quiet - 1;
                        send_gap   <= 0;
                    end
                    else
                    begin
                        send_gap <= $urandom_range(0, 3);
                        if ($urandom_range(0, 15) == 0)
                            send_quiet <= $urandom_range(8, 24);
                    end
                end
            end
            s_tvalid <= send_valid;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random stalls on the result side, field checks
    // ---------------------------------------------------------------

    int recv_stall = 0;
    int recv_quiet = 0;
    int recv_next;
    parse_result_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            recv_stall <= 0;
            recv_quiet <= 0;
        end
        else
        begin
            recv_next = recv_stall;
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("[%0d] result with none expected: value %h error %b",
                                 cycle_count, m_tdata, m_tuser);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.value)
                        report_field("parsed_value", want.value, m_tdata);
                    if (m_tuser !== want.bad)
                        report_field("parse_error", 32'(want.bad), 32'(m_tuser));
                end
                if (recv_quiet > 0)
                begin
                    recv_quiet <= recv_quiet - 1;
                    recv_next = 0;
                end
                else
                begin
                    recv_next = $urandom_range(0, 3);
                    if ($urandom_range(0, 7) == 0)
                        recv_quiet <= $urandom_range(4, 12);
                end
            end
            else if (recv_next > 0)
                recv_next = recv_next - 1;
            recv_stall <= recv_next;
            m_tready   <= (recv_next == 0);
        end
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------

    initial
    begin
        reset_parser();

        // NUL as first byte, then a top-bit byte
        text_buf.push_back(CHAR_NUL);
        emit_text(1'b0);
        text_buf.push_back(8'hFF);
        emit_text(1'b0);
        // leading blanks and minus zero
        text_buf.push_back(CHAR_SPACE);
        text_buf.push_back(CHAR_TAB);
        push_str("-0");
        emit_text(1'b0);
        // hex prefix with no digit
        push_str("0x");
        emit_text(1'b0);
        // nine in an octal text
        push_str("09");
        emit_text(1'b0);
        // early NUL, byte after it ignored
        push_str("7");
        text_buf.push_back(CHAR_NUL);
        push_str("z");
        emit_text(1'b0);
        // mixed-case hex
        push_str("0XfF");
        emit_text(1'b0);
        // negative nonzero
        push_str("-5");
        emit_text(1'b0);
        // trailing blank
        push_str("12 ");
        emit_text(1'b0);
        // sign only, no digits
        push_str("+");
        emit_text(1'b0);
        push_str("0");
        emit_text(1'b0);

        // random texts; a few wait for all results before starting
        while (byte_total < TARGET_BYTES)
        begin
            if ($urandom_range(0, 9) == 0)
                build_noise();
            else
                build_number();
            emit_text(text_total == 11 || text_total % 25 == 0);
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (text_bytes.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_WAIT) @(posedge clk);

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
